[hdl/task_runtime_statistics_assert.svh]
// assertion macros used by the runtime statistics controller
`ifndef TASK_RUNTIME_STATISTICS_ASSERT_SVH
`define TASK_RUNTIME_STATISTICS_ASSERT_SVH

// same-cycle implication on clk, off during reset
`define TRS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("runtime statistics check failed");

// next-cycle implication on clk, off during reset
`define TRS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("runtime statistics check failed");

`endif

[hdl/trs_pkg.sv]
// types and codes shared by the runtime statistics block
package trs_pkg;

	localparam int unsigned FIELD_BITS = 32;

	typedef enum logic [1:0] {
		CMD_ADD     = 2'd0,
		CMD_CLR_MAX = 2'd1,
		CMD_READ    = 2'd2
	} trs_cmd_t;

	typedef struct packed {
		logic [1:0]            cmd;
		logic [FIELD_BITS-1:0] sample;
	} trs_in_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] current_max;
		logic [FIELD_BITS-1:0] overall_max;
		logic [FIELD_BITS-1:0] average;
		logic [FIELD_BITS-1:0] sample_count;
		logic [FIELD_BITS-1:0] eaten_count;
	} trs_out_t;

	typedef struct packed {
		logic apply;
		logic div_load;
		logic div_step;
		logic out_load;
	} trs_ctl_t;

	typedef struct packed {
		logic eff_zero;
	} trs_sts_t;

endpackage

[hdl/task_runtime_statistics.sv]
// Runtime statistics monitor. Each input beat carries a command (add a sample,
// clear the current maximum, or only read) and returns one output beat with
// the current maximum, overall maximum, average, sample count and eaten count.
// An item passes through the block in order: the command is applied, the
// divider is loaded, VALUE_WIDTH steps of the bit-serial divider form the
// average, and the output register is loaded once any earlier result has
// been taken. When the effective count is zero the divider is skipped. The
// output register lets the next beat in while a result still waits to be
// taken.
module task_runtime_statistics #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  trs_pkg::trs_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output trs_pkg::trs_out_t out_data
);
	import trs_pkg::*;

	trs_ctl_t ctl;
	trs_sts_t sts;

	trs_ctrl #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	trs_datapath #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_data (in_data),
		.ctl     (ctl),
		.sts     (sts),
		.out_data(out_data)
	);

endmodule

[hdl/trs_ctrl.sv]
// controller state machine: sequences update, divide and result load
`include "task_runtime_statistics_assert.svh"

module trs_ctrl #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  trs_pkg::trs_sts_t sts,
	output trs_pkg::trs_ctl_t ctl
);
	import trs_pkg::*;

	localparam int unsigned CW = $clog2(VALUE_WIDTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_DIV,
		S_EMIT
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  cnt_q;
	logic           out_valid_q;
	logic           slot_free;

	assign slot_free    = !out_valid_q || out_ready;
	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign ctl.apply    = in_valid && in_ready;
	assign ctl.div_load = (state_q == S_LOAD);
	assign ctl.div_step = (state_q == S_DIV);
	assign ctl.out_load = (state_q == S_EMIT) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					cnt_q <= '0;
					if (sts.eff_zero) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(VALUE_WIDTH - 1)) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`TRS_ASSERT_SAME(a_no_overwrite, ctl.out_load, (!out_valid_q || out_ready))
	`TRS_ASSERT_NEXT(a_load_shows, ctl.out_load, (out_valid_q && state_q == S_IDLE))
	`TRS_ASSERT_SAME(a_div_length,
		(state_q == S_EMIT && $past(state_q) != S_EMIT),
		($past(state_q) == S_LOAD || $past(cnt_q) == CW'(VALUE_WIDTH - 1)))
	`TRS_ASSERT_NEXT(a_accept_loads, ctl.apply, (state_q == S_LOAD))

endmodule

[hdl/trs_datapath.sv]
// datapath: statistics registers, bit-serial divider, result register
module trs_datapath #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  trs_pkg::trs_in_t  in_data,
	input  trs_pkg::trs_ctl_t ctl,
	output trs_pkg::trs_sts_t sts,
	output trs_pkg::trs_out_t out_data
);
	import trs_pkg::*;

	localparam int unsigned VW = VALUE_WIDTH;
	localparam int unsigned XW = (VW > FIELD_BITS) ? VW : FIELD_BITS;

	logic [VW-1:0] max_now_q;
	logic [VW-1:0] max_start_q;
	logic [VW-1:0] sum_q;
	logic [VW-1:0] total_q;
	logic [VW-1:0] disc_q;

	logic [VW-1:0] rem_q;
	logic [VW-1:0] quo_q;
	logic [VW-1:0] dvs_q;
	trs_out_t      out_q;

	logic [XW-1:0] smp_x;
	logic [VW-1:0] smp;
	logic [VW:0]   sum_ext;
	logic          carry;
	logic [VW-1:0] eff;
	logic [VW-1:0] larger;
	logic [VW:0]   shifted;
	logic [VW:0]   diff;

	logic [XW-1:0] cur_x;
	logic [XW-1:0] all_x;
	logic [XW-1:0] avg_x;
	logic [XW-1:0] cnt_x;
	logic [XW-1:0] eat_x;

	assign smp_x   = XW'(in_data.sample);
	assign smp     = smp_x[VW-1:0];
	assign sum_ext = {1'b0, sum_q} + {1'b0, smp};
	assign carry   = sum_ext[VW];
	assign eff     = total_q - disc_q;
	assign larger  = (max_now_q > max_start_q) ? max_now_q : max_start_q;
	assign sts.eff_zero = (eff == '0);

	// one restoring divide step per cycle
	assign shifted = {rem_q, quo_q[VW-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_now_q   <= '0;
			max_start_q <= '0;
			sum_q       <= '0;
			total_q     <= '0;
			disc_q      <= '0;
		end else if (ctl.apply) begin
			case (trs_cmd_t'(in_data.cmd))
				CMD_ADD: begin
					if (smp > max_now_q) begin
						max_now_q <= smp;
					end
					if (carry) begin
						sum_q  <= (sum_q >> 1) + smp;
						disc_q <= disc_q + (eff >> 1);
					end else begin
						sum_q <= sum_ext[VW-1:0];
					end
					total_q <= total_q + 1'b1;
				end
				CMD_CLR_MAX: begin
					max_start_q <= larger;
					max_now_q   <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.div_load) begin
			rem_q <= '0;
			quo_q <= sum_q;
			dvs_q <= eff;
		end else if (ctl.div_step) begin
			if (!diff[VW]) begin
				rem_q <= diff[VW-1:0];
				quo_q <= {quo_q[VW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[VW-1:0];
				quo_q <= {quo_q[VW-2:0], 1'b0};
			end
		end
	end

	assign cur_x = XW'(max_now_q);
	assign all_x = XW'(larger);
	assign avg_x = sts.eff_zero ? '0 : XW'(quo_q);
	assign cnt_x = XW'(total_q);
	assign eat_x = XW'(disc_q);

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_q.current_max  <= cur_x[FIELD_BITS-1:0];
			out_q.overall_max  <= all_x[FIELD_BITS-1:0];
			out_q.average      <= avg_x[FIELD_BITS-1:0];
			out_q.sample_count <= cnt_x[FIELD_BITS-1:0];
			out_q.eaten_count  <= eat_x[FIELD_BITS-1:0];
		end
	end

	assign out_data = out_q;

endmodule
